// ----- rtl/core/bba_pkg.sv -----
// Package for the buddy block allocator: pool constants, status codes and table types.
package bba_pkg;

  // Pool geometry. The payload field widths fix a pool of 1024 bytes.
  localparam int unsigned TOTAL_BYTES     = 1024;
  localparam int unsigned HEADER_BYTES    = 24;
  localparam int unsigned MIN_BLOCK_BYTES = 32;

  localparam int unsigned NUM_SLOTS = TOTAL_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned OFF_LSB   = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned TOP_ORDER = SLOT_W;
  localparam int unsigned ORDER_W   = 3;

  // Field widths
  localparam int unsigned REQ_W    = 11;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned GBYTES_W = 11;
  localparam int unsigned STATUS_W = 2;

  // Room for a request plus header, and for any block size an order code can name
  localparam int unsigned NEED_W  = REQ_W + 1;
  localparam int unsigned BYTES_W = OFF_LSB + (1 << ORDER_W) + 1;

  // Request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_FIT   = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  // One slot of the block table
  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic               head;
    logic               used;
  } slot_entry_t;

  // Write command into the block table
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } table_wr_t;

  // Size in bytes of a block of the given order
  function automatic logic [BYTES_W-1:0] bytes_of(input logic [ORDER_W-1:0] ord);
    bytes_of = BYTES_W'(MIN_BLOCK_BYTES) << ord;
  endfunction

endpackage

// ----- rtl/core/bba_slot_table.sv -----
// Block table: order, head and used mark of every slot, one read and one write per cycle.
module bba_slot_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bba_pkg::SLOT_W-1:0]   rd_addr_i,
  output bba_pkg::slot_entry_t         rd_data_o,
  input  bba_pkg::table_wr_t           wr_i
);
  import bba_pkg::*;

  logic [ORDER_W-1:0] order_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] head_q;
  logic [NUM_SLOTS-1:0] used_q;

  // Read port, straight from the flops
  assign rd_data_o.order = order_q[rd_addr_i];
  assign rd_data_o.head  = head_q[rd_addr_i];
  assign rd_data_o.used  = used_q[rd_addr_i];

  // Reset leaves one free block spanning the whole pool
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        order_q[k] <= '0;
      end
      order_q[0] <= ORDER_W'(TOP_ORDER);
      head_q     <= NUM_SLOTS'(1);
      used_q     <= '0;
    end else if (wr_i.en) begin
      order_q[wr_i.addr] <= wr_i.data.order;
      head_q[wr_i.addr]  <= wr_i.data.head;
      used_q[wr_i.addr]  <= wr_i.data.used;
    end
  end

endmodule

// ----- rtl/core/buddy_block_allocator.sv -----
// Buddy block allocator: sequencer that walks the block table one entry per cycle.
//
// Usage: one input channel (in_valid_i / in_ready_o) carries a request: func_i
// selects allocate or free, request_bytes_i is the payload size for allocate,
// block_offset_i the header offset for free. Each request gives exactly one
// result on the output channel (out_valid_o / out_ready_i): status, granted
// offset and granted size (offset and size are zero unless an allocate works).
// Steps: an allocate scans the blocks in address order (up to 32 visited), halves
// the found block while half of it still fits, marks it used and posts the result.
// A free checks and unmarks the block, merges it with its free buddy level by
// level (up to 5 merges) and posts the result; a rejected free skips the merge.
// The walk reads the table through its single read port.
// One request is worked on at a time; in_ready_o is high while idle, even when a
// result still waits on the output register.
// A stalled receiver holds the result in the output register; the next request
// can be taken and worked, but its result waits until the previous one is taken.
// Reset (rst_ni low, asynchronous) clears the table to one free block covering
// the whole pool and drops any pending result.
module buddy_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [bba_pkg::REQ_W-1:0]     request_bytes_i,
  input  logic [bba_pkg::OFF_W-1:0]     block_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bba_pkg::STATUS_W-1:0]  status_o,
  output logic [bba_pkg::OFF_W-1:0]     granted_offset_o,
  output logic [bba_pkg::GBYTES_W-1:0]  granted_bytes_o
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_FREE_CHK,
    ST_MERGE_RD,
    ST_MERGE_WR,
    ST_DONE
  } state_e;

  localparam int unsigned SCAN_W = SLOT_W + (1 << ORDER_W) + 1;

  state_e             state_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [ORDER_W-1:0] ord_q;
  logic [NEED_W-1:0]  need_q;
  status_e            status_q;
  logic               grant_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [OFF_W-1:0]     out_offset_q;
  logic [GBYTES_W-1:0]  out_bytes_q;

  logic [SLOT_W-1:0]  rd_addr;
  slot_entry_t        rd_data;
  table_wr_t          tbl_wr;

  logic [SCAN_W-1:0]  scan_next;
  logic [BYTES_W-1:0] cur_bytes;
  logic [BYTES_W-1:0] ord_bytes;
  logic               fits;
  logic               split_ok;
  logic [SLOT_W-1:0]  split_slot;
  logic [SLOT_W-1:0]  merge_bit;
  logic               merge_lvl_ok;
  logic               buddy_ok;
  logic               out_free;

  bba_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (tbl_wr)
  );

  // Shared compare and step logic
  assign cur_bytes    = bytes_of(rd_data.order);
  assign ord_bytes    = bytes_of(ord_q);
  assign fits         = rd_data.head && !rd_data.used && (cur_bytes >= BYTES_W'(need_q));
  assign scan_next    = SCAN_W'(slot_q) + (SCAN_W'(1) << rd_data.order);
  assign split_ok     = (ord_q != '0) && ((ord_bytes >> 1) >= BYTES_W'(need_q));
  assign split_slot   = slot_q + (SLOT_W'(1) << (ord_q - ORDER_W'(1)));
  assign merge_bit    = SLOT_W'(1) << ord_q;
  assign merge_lvl_ok = ord_q < ORDER_W'(TOP_ORDER);
  assign buddy_ok     = rd_data.head && !rd_data.used && (rd_data.order == ord_q);
  assign out_free     = !out_valid_q || out_ready_i;

  // Table read address
  always_comb begin
    case (state_q)
      ST_MERGE_RD: rd_addr = slot_q ^ merge_bit;
      default:     rd_addr = slot_q;
    endcase
  end

  // Table write command
  always_comb begin
    tbl_wr = '0;
    case (state_q)
      ST_SPLIT: begin
        tbl_wr.en = 1'b1;
        if (split_ok) begin
          tbl_wr.addr       = split_slot;
          tbl_wr.data.order = ord_q - ORDER_W'(1);
          tbl_wr.data.head  = 1'b1;
          tbl_wr.data.used  = 1'b0;
        end else begin
          tbl_wr.addr       = slot_q;
          tbl_wr.data.order = ord_q;
          tbl_wr.data.head  = 1'b1;
          tbl_wr.data.used  = 1'b1;
        end
      end
      ST_FREE_CHK: begin
        tbl_wr.en         = rd_data.head && rd_data.used;
        tbl_wr.addr       = slot_q;
        tbl_wr.data.order = rd_data.order;
        tbl_wr.data.head  = 1'b1;
        tbl_wr.data.used  = 1'b0;
      end
      ST_MERGE_RD: begin
        // the upper half of a merged pair stops being a block
        tbl_wr.en   = merge_lvl_ok && buddy_ok;
        tbl_wr.addr = slot_q | merge_bit;
      end
      ST_MERGE_WR: begin
        tbl_wr.en         = 1'b1;
        tbl_wr.addr       = slot_q;
        tbl_wr.data.order = ord_q;
        tbl_wr.data.head  = 1'b1;
        tbl_wr.data.used  = 1'b0;
      end
      default: tbl_wr = '0;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      slot_q       <= '0;
      ord_q        <= '0;
      need_q       <= '0;
      status_q     <= STATUS_DONE;
      grant_q      <= 1'b0;
      out_status_q <= '0;
      out_offset_q <= '0;
      out_bytes_q  <= '0;
    end else begin
      // a taken result drops out unless the next one is posted in its place
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            grant_q  <= 1'b0;
            status_q <= STATUS_DONE;
            need_q   <= NEED_W'(request_bytes_i) + NEED_W'(HEADER_BYTES);
            if (func_i == FUNC_ALLOC) begin
              slot_q  <= '0;
              state_q <= ST_SCAN;
            end else begin
              slot_q <= block_offset_i[OFF_LSB +: SLOT_W];
              if (block_offset_i[OFF_LSB-1:0] != '0) begin
                status_q <= STATUS_BAD_FREE;
                state_q  <= ST_DONE;
              end else begin
                state_q <= ST_FREE_CHK;
              end
            end
          end
        end
        ST_SCAN: begin
          if (fits) begin
            ord_q   <= rd_data.order;
            state_q <= ST_SPLIT;
          end else if (scan_next >= SCAN_W'(NUM_SLOTS)) begin
            status_q <= STATUS_NO_FIT;
            state_q  <= ST_DONE;
          end else begin
            slot_q <= scan_next[SLOT_W-1:0];
          end
        end
        ST_SPLIT: begin
          if (split_ok) begin
            ord_q <= ord_q - ORDER_W'(1);
          end else begin
            grant_q <= 1'b1;
            state_q <= ST_DONE;
          end
        end
        ST_FREE_CHK: begin
          if (!rd_data.head || !rd_data.used) begin
            status_q <= STATUS_BAD_FREE;
            state_q  <= ST_DONE;
          end else begin
            ord_q   <= rd_data.order;
            state_q <= ST_MERGE_RD;
          end
        end
        ST_MERGE_RD: begin
          if (merge_lvl_ok && buddy_ok) begin
            slot_q  <= slot_q & ~merge_bit;
            ord_q   <= ord_q + ORDER_W'(1);
            state_q <= ST_MERGE_WR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_MERGE_WR: begin
          state_q <= ST_MERGE_RD;
        end
        ST_DONE: begin
          // post the result once the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_offset_q <= grant_q ? OFF_W'({slot_q, OFF_LSB'(0)}) : '0;
            out_bytes_q  <= grant_q ? ord_bytes[GBYTES_W-1:0] : '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_offset_q;
  assign granted_bytes_o  = out_bytes_q;

`ifndef ASSERT_OFF
  // A failed request reports no block
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_DONE) |-> (granted_bytes_o == '0) &&
      (granted_offset_o == '0))
    else $error("failed request reports a granted block");

  // A granted block is aligned to its own size
  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (granted_bytes_o != '0) |->
      ((granted_offset_o & (granted_bytes_o[OFF_W-1:0] - OFF_W'(1))) == '0))
    else $error("granted block is not aligned to its size");

  // Slot zero always starts a block
  a_slot0_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en && (tbl_wr.addr == '0) |-> tbl_wr.data.head)
    else $error("write clears the head mark of slot zero");

  // No request is taken while one is in progress
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("ready raised while a request is in progress");
`endif

endmodule

// ----- dv/bba_grant_checker.sv -----
// Checker for the buddy block allocator: tracks the block table and compares every result.
`timescale 1ns / 100ps

module bba_grant_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         func_i,
  input  logic [bba_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [bba_pkg::OFF_W-1:0]    block_offset_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [bba_pkg::STATUS_W-1:0] status_i,
  input  logic [bba_pkg::OFF_W-1:0]    granted_offset_i,
  input  logic [bba_pkg::GBYTES_W-1:0] granted_bytes_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import bba_pkg::*;

  // One predicted result
  typedef struct packed {
    status_e             status;
    logic [OFF_W-1:0]    offset;
    logic [GBYTES_W-1:0] nbytes;
  } grant_t;

  // Shadow block table, one entry per slot
  logic [ORDER_W-1:0] ord_tbl  [NUM_SLOTS];
  logic               head_tbl [NUM_SLOTS];
  logic               used_tbl [NUM_SLOTS];

  grant_t grant_q [$];

  // First-fit scan in address order, then split down while half still fits
  function automatic grant_t serve_alloc(input logic [REQ_W-1:0] req);
    int unsigned need;
    int unsigned slot;
    int unsigned ord;
    int unsigned buddy;
    grant_t      g;
    need     = req + HEADER_BYTES;
    slot     = 0;
    g.status = STATUS_NO_FIT;
    g.offset = '0;
    g.nbytes = '0;
    while (slot < NUM_SLOTS) begin
      ord = ord_tbl[slot];
      if (head_tbl[slot] && !used_tbl[slot] && (MIN_BLOCK_BYTES << ord) >= need) break;
      slot += 1 << ord;
    end
    if (slot < NUM_SLOTS) begin
      ord = ord_tbl[slot];
      while (ord > 0 && ((MIN_BLOCK_BYTES << ord) >> 1) >= need) begin
        ord--;
        buddy           = slot + (1 << ord);
        head_tbl[buddy] = 1'b1;
        used_tbl[buddy] = 1'b0;
        ord_tbl[buddy]  = ORDER_W'(ord);
      end
      ord_tbl[slot]  = ORDER_W'(ord);
      used_tbl[slot] = 1'b1;
      g.status       = STATUS_DONE;
      g.offset       = OFF_W'(slot * MIN_BLOCK_BYTES);
      g.nbytes       = GBYTES_W'(MIN_BLOCK_BYTES << ord);
    end
    return g;
  endfunction

  // Unmark a used block, then merge with free same-order buddies upward
  function automatic grant_t serve_free(input logic [OFF_W-1:0] off);
    int unsigned slot;
    int unsigned ord;
    int unsigned bit_m;
    grant_t      g;
    g.status = STATUS_BAD_FREE;
    g.offset = '0;
    g.nbytes = '0;
    slot     = off / MIN_BLOCK_BYTES;
    if ((off % MIN_BLOCK_BYTES) == 0 && slot < NUM_SLOTS &&
        head_tbl[slot] && used_tbl[slot]) begin
      used_tbl[slot] = 1'b0;
      ord            = ord_tbl[slot];
      while (ord < TOP_ORDER) begin
        bit_m = 1 << ord;
        if (!head_tbl[slot ^ bit_m] || used_tbl[slot ^ bit_m] ||
            ord_tbl[slot ^ bit_m] != ord) break;
        slot                  &= ~bit_m;
        head_tbl[slot | bit_m] = 1'b0;
        ord_tbl[slot | bit_m]  = '0;
        ord++;
        ord_tbl[slot] = ORDER_W'(ord);
      end
      g.status = STATUS_DONE;
    end
    return g;
  endfunction

  // Compare accepted results, then predict for the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        ord_tbl[s]  = '0;
        head_tbl[s] = 1'b0;
        used_tbl[s] = 1'b0;
      end
      ord_tbl[0]  = ORDER_W'(TOP_ORDER);
      head_tbl[0] = 1'b1;
      grant_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          $error("result with nothing expected: status %0d offset %0d bytes %0d",
                 status_i, granted_offset_i, granted_bytes_i);
          fail_count_o++;
        end else begin
          want = grant_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count_o++;
          end
          if (granted_offset_i !== want.offset) begin
            $error("granted_offset: expected %0d, actual %0d", want.offset, granted_offset_i);
            fail_count_o++;
          end
          if (granted_bytes_i !== want.nbytes) begin
            $error("granted_bytes: expected %0d, actual %0d", want.nbytes, granted_bytes_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == FUNC_FREE) grant_q.push_back(serve_free(block_offset_i));
        else grant_q.push_back(serve_alloc(request_bytes_i));
      end
      pending_o = grant_q.size();
    end
  end

endmodule

// ----- dv/buddy_block_allocator_test.sv -----
// Testbench top for the buddy block allocator: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module buddy_block_allocator_test;
  import bba_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 410;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned MAX_GAP      = 64;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                func;
  logic [REQ_W-1:0]    request_bytes;
  logic [OFF_W-1:0]    block_offset;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    granted_offset;
  logic [GBYTES_W-1:0] granted_bytes;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;

  // Offsets of blocks currently granted, for well-formed frees
  logic [OFF_W-1:0] live_q [$];
  logic [OFF_W-1:0] last_freed;

  buddy_block_allocator u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func),
    .request_bytes_i  (request_bytes),
    .block_offset_i   (block_offset),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .granted_offset_o (granted_offset),
    .granted_bytes_o  (granted_bytes)
  );

  bba_grant_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .func_i           (func),
    .request_bytes_i  (request_bytes),
    .block_offset_i   (block_offset),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .granted_offset_i (granted_offset),
    .granted_bytes_i  (granted_bytes),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  // Track granted blocks as results go out
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && status == STATUS_DONE && granted_bytes != 0)
      live_q.push_back(granted_offset);
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request; called and returns at a falling edge
  task automatic offer_request(input logic f, input logic [REQ_W-1:0] req,
                               input logic [OFF_W-1:0] off);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < MAX_GAP)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    request_bytes <= req;
    block_offset  <= off;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Random payload size, mostly small so the pool fills up
  function automatic logic [REQ_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return REQ_W'($urandom_range(0, 8));
    if (r < 75) return REQ_W'($urandom_range(9, 100));
    if (r < 90) return REQ_W'($urandom_range(101, 488));
    if (r < 97) return REQ_W'($urandom_range(489, 1000));
    return REQ_W'($urandom_range(1001, 1024));
  endfunction

  // Mix of allocations, frees of live blocks, and broken frees
  task automatic random_request();
    int unsigned      r;
    int unsigned      idx;
    int unsigned      free_pct;
    logic [OFF_W-1:0] off;
    r        = $urandom_range(0, 99);
    free_pct = (live_q.size() > 8) ? 55 : 35;
    if (r < 10) begin
      case ($urandom_range(0, 2))
        0:       off = OFF_W'($urandom);
        1:       off = OFF_W'($urandom_range(0, NUM_SLOTS - 1) * MIN_BLOCK_BYTES);
        default: off = last_freed;
      endcase
      offer_request(FUNC_FREE, REQ_W'($urandom_range(0, 1024)), off);
    end else if (live_q.size() != 0 && r < 10 + free_pct) begin
      idx = $urandom_range(0, live_q.size() - 1);
      off = live_q[idx];
      live_q.delete(idx);
      last_freed = off;
      offer_request(FUNC_FREE, REQ_W'($urandom_range(0, 1024)), off);
    end else begin
      offer_request(FUNC_ALLOC, pick_size(), OFF_W'($urandom));
    end
  endtask

  initial begin
    int unsigned idle_tbl  [4];
    int unsigned stall_tbl [4];
    idle_tbl  = '{0, 82, 0, 31};
    stall_tbl = '{0, 0, 82, 31};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    func           = FUNC_ALLOC;
    request_bytes  = '0;
    block_offset   = '0;
    hold_req       = 1'b0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    last_freed     = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: oversize, whole pool, zero-byte, smallest block, bad frees, merges
    offer_request(FUNC_ALLOC, 11'd1024, OFF_W'($urandom));
    offer_request(FUNC_ALLOC, 11'd1001, OFF_W'($urandom));
    offer_request(FUNC_ALLOC, 11'd1000, OFF_W'($urandom));
    offer_request(FUNC_ALLOC, 11'd0, OFF_W'($urandom));
    offer_request(FUNC_FREE, REQ_W'($urandom_range(0, 1024)), 10'd0);
    offer_request(FUNC_FREE, REQ_W'($urandom_range(0, 1024)), 10'd0);
    offer_request(FUNC_ALLOC, 11'd0, OFF_W'($urandom));
    offer_request(FUNC_ALLOC, 11'd8, OFF_W'($urandom));
    offer_request(FUNC_ALLOC, 11'd9, OFF_W'($urandom));
    offer_request(FUNC_FREE, 11'd0, 10'd33);
    offer_request(FUNC_FREE, 11'd1024, 10'd1023);
    offer_request(FUNC_FREE, 11'd0, 10'd992);
    offer_request(FUNC_FREE, 11'd0, 10'd512);
    offer_request(FUNC_FREE, 11'd0, 10'd32);
    offer_request(FUNC_FREE, 11'd0, 10'd0);
    offer_request(FUNC_FREE, 11'd0, 10'd64);
    offer_request(FUNC_ALLOC, 11'd488, 10'd1023);
    offer_request(FUNC_ALLOC, 11'd489, 10'd0);
    offer_request(FUNC_ALLOC, 11'd488, OFF_W'($urandom));
    offer_request(FUNC_FREE, 11'd0, 10'd512);
    offer_request(FUNC_FREE, 11'd0, 10'd0);
    wait_drained();
    live_q.delete();

    // Random phases with different idle patterns
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tbl[p];
      recv_stall_pct = stall_tbl[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while requests keep coming
        if (p == 0 && n == 100) hold_req = 1'b1;
        random_request();
      end
      wait_drained();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
